[sv/pbc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Partitioned block convolver package
// Sizes, the accumulator width and the output rounding shared by all files.
// ----------------------------------------------------------------------------
package pbc_pkg;

    localparam int BLOCK_SIZE  = 64;
    localparam int PARTITIONS  = 16;
    localparam int SAMPLE_BITS = 16;
    localparam int COEF_BITS   = 16;
    localparam int TAP_DEPTH   = PARTITIONS * BLOCK_SIZE;
    localparam int TAP_AW      = $clog2(TAP_DEPTH);
    localparam int TCNT_W      = TAP_AW + 1;
    // The sample ring holds the current block and a full tap span behind it.
    localparam int RING_DEPTH  = 2 * TAP_DEPTH;
    localparam int RING_AW     = $clog2(RING_DEPTH);
    localparam int ROW_W       = $clog2(BLOCK_SIZE);
    localparam int PROD_W      = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_W       = PROD_W + TAP_AW;
    localparam int SHIFT_W     = ACC_W - (COEF_BITS - 1);

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TAP    = 1'b1;

    typedef struct packed {
        logic load;
        logic last;
    } pbc_emit_t;

    // Round half up at the Q1.15 point, then saturate to the sample width.
    function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
        input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0]   biased;
        logic signed [SHIFT_W-1:0] shifted;
        logic signed [SHIFT_W-1:0] maxv;
        logic signed [SHIFT_W-1:0] minv;
        biased  = acc + (ACC_W'(1) <<< (COEF_BITS - 2));
        shifted = SHIFT_W'(biased >>> (COEF_BITS - 1));
        maxv    = SHIFT_W'((1 << (SAMPLE_BITS - 1)) - 1);
        minv    = -maxv - SHIFT_W'(1);
        if (shifted > maxv)
            return SAMPLE_BITS'(maxv);
        else if (shifted < minv)
            return SAMPLE_BITS'(minv);
        else
            return shifted[SAMPLE_BITS-1:0];
    endfunction

endpackage

[sv/pbc_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Partitioned block convolver channels
// Valid/ready interfaces for input items and for filtered results.
// ----------------------------------------------------------------------------
interface pbc_in_if import pbc_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic                          op;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic        [TAP_AW-1:0]      tap_index;
    logic signed [COEF_BITS-1:0]   tap_value;

    modport source (output valid, op, sample, tap_index, tap_value, input ready);
    modport sink   (input valid, op, sample, tap_index, tap_value, output ready);
endinterface

interface pbc_out_if import pbc_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] out_sample;
    logic                          out_last;

    modport source (output valid, out_sample, out_last, input ready);
    modport sink   (input valid, out_sample, out_last, output ready);
endinterface

[sv/pbc_out_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Output stage
// Rounds and saturates a finished sum and holds it until the beat is taken.
// ----------------------------------------------------------------------------
module pbc_out_stage
    import pbc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  pbc_emit_t               emit,
    input  logic signed [ACC_W-1:0] acc,
    output logic                    can_load,
    pbc_out_if.source               result_ch
);

    logic                          valid_reg;
    logic signed [SAMPLE_BITS-1:0] data_reg;
    logic                          last_reg;

    assign can_load = !valid_reg || result_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (emit.load && can_load)
        begin
            valid_reg <= 1'b1;
        end
        else if (result_ch.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.load && can_load)
        begin
            data_reg <= round_sat(acc);
            last_reg <= emit.last;
        end
    end

    assign result_ch.valid      = valid_reg;
    assign result_ch.out_sample = data_reg;
    assign result_ch.out_last   = last_reg;

endmodule

[sv/partitioned_block_convolver.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Partitioned block convolver
// Long FIR filter over a sample stream, computed block by block with one
// multiply-accumulate per cycle against a coefficient memory and a sample ring.
// ----------------------------------------------------------------------------
//  Channel      | Role      | Beat contents
//  -------------+-----------+------------------------------------------------
//  sample_ch    | sink      | op, sample, tap_index, tap_value
//  result_ch    | source    | out_sample, out_last
//  cfg_wr_*     | write     | tap_count (11 bits), no read-back
//
//  After reset a clearing pass over all RING_DEPTH (2048) ring entries
//  zeroes both memories; no beat is accepted until it ends.
//  A tap write or a sample that does not complete a block is only stored.
//  The sample that completes a block starts the computation of BLOCK_SIZE
//  results; each steps through the taps in use, one multiply-accumulate per
//  cycle, drains the read and product registers and goes to the output
//  stage, with the tap steps skipped when no taps are in use; the pace is set
//  by the single multiplier and the one read port of each memory.
//  The input is held off while a block is computed; a stalled result only
//  holds the computation at the end of a row, in the output register.
// ----------------------------------------------------------------------------
module partitioned_block_convolver
    import pbc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [TCNT_W-1:0] cfg_wr_data,
    pbc_in_if.sink            sample_ch,
    pbc_out_if.source         result_ch
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    // Coefficients and the sample ring. The ring is written at the push
    // pointer only while idle, and its reads are used only while a block is
    // computed, so no read that is used meets a write on one entry.
    logic signed [COEF_BITS-1:0]   coef_mem [TAP_DEPTH];
    logic signed [SAMPLE_BITS-1:0] samp_mem [RING_DEPTH];

    state_t                        state_reg;
    logic [RING_AW-1:0]            clr_cnt_reg;
    logic [TCNT_W-1:0]             tap_count_reg;
    logic [RING_AW-1:0]            wp_reg;
    logic [ROW_W-1:0]              fill_reg;
    logic [RING_AW-1:0]            start_reg;
    logic [ROW_W-1:0]              row_reg;
    logic [TAP_AW-1:0]             k_reg;
    logic                          v1_reg;
    logic                          v2_reg;
    logic signed [COEF_BITS-1:0]   coef_rd_reg;
    logic signed [SAMPLE_BITS-1:0] samp_rd_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [ACC_W-1:0]       acc_reg;

    logic [TCNT_W-1:0]  taps;
    logic               accept;
    logic               tap_wr;
    logic               samp_wr;
    logic               block_done;
    logic               last_tap;
    logic [RING_AW-1:0] rd_addr;
    logic               can_load;
    pbc_emit_t          emit;

    // A tap count above the memory saturates to the full depth.
    assign taps = (tap_count_reg > TCNT_W'(TAP_DEPTH)) ? TCNT_W'(TAP_DEPTH) : tap_count_reg;

    assign sample_ch.ready = (state_reg == ST_IDLE);
    assign accept          = sample_ch.valid && sample_ch.ready;
    assign tap_wr          = accept && (sample_ch.op == OP_TAP);
    assign samp_wr         = accept && (sample_ch.op == OP_SAMPLE);
    assign block_done      = samp_wr && (fill_reg == ROW_W'(BLOCK_SIZE - 1));
    assign last_tap        = (TCNT_W'(k_reg) == taps - TCNT_W'(1));

    // Sample that lag k stands before output row i of the current block.
    assign rd_addr = start_reg + RING_AW'(row_reg) - RING_AW'(k_reg);

    assign emit.load = (state_reg == ST_EMIT);
    assign emit.last = (row_reg == ROW_W'(BLOCK_SIZE - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= TCNT_W'(TAP_DEPTH);
        end
        else if (cfg_wr_en)
        begin
            tap_count_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
        begin
            coef_mem[clr_cnt_reg[TAP_AW-1:0]] <= '0;
        end
        else if (tap_wr)
        begin
            coef_mem[sample_ch.tap_index] <= sample_ch.tap_value;
        end
        coef_rd_reg <= coef_mem[k_reg];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
        begin
            samp_mem[clr_cnt_reg] <= '0;
        end
        else if (samp_wr)
        begin
            samp_mem[wp_reg] <= sample_ch.sample;
        end
        samp_rd_reg <= samp_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= coef_rd_reg * samp_rd_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            wp_reg      <= '0;
            fill_reg    <= '0;
            start_reg   <= '0;
            row_reg     <= '0;
            k_reg       <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            acc_reg     <= '0;
        end
        else
        begin
            v1_reg <= (state_reg == ST_MAC);
            v2_reg <= v1_reg;
            if (v2_reg)
            begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end

            case (state_reg)
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + RING_AW'(1);
                    if (clr_cnt_reg == RING_AW'(RING_DEPTH - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (samp_wr)
                    begin
                        wp_reg   <= wp_reg + RING_AW'(1);
                        fill_reg <= fill_reg + ROW_W'(1);
                    end
                    if (block_done)
                    begin
                        // The block begins BLOCK_SIZE-1 entries behind this sample.
                        start_reg <= wp_reg - RING_AW'(BLOCK_SIZE - 1);
                        row_reg   <= '0;
                        k_reg     <= '0;
                        acc_reg   <= '0;
                        state_reg <= (taps == '0) ? ST_DRAIN : ST_MAC;
                    end
                end
                ST_MAC:
                begin
                    if (last_tap)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        k_reg <= k_reg + TAP_AW'(1);
                    end
                end
                ST_DRAIN:
                begin
                    if (!v1_reg && !v2_reg)
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (can_load)
                    begin
                        k_reg   <= '0;
                        acc_reg <= '0;
                        if (emit.last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            row_reg   <= row_reg + ROW_W'(1);
                            state_reg <= (taps == '0) ? ST_DRAIN : ST_MAC;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    pbc_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .emit      (emit),
        .acc       (acc_reg),
        .can_load  (can_load),
        .result_ch (result_ch)
    );

    // The tap counter never runs past the taps in use.
    a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MAC) |-> (TCNT_W'(k_reg) < taps))
        else $error("tap counter beyond tap count");

    // A product is flagged valid only in the cycle after its operand reads were flagged valid.
    a_pipe_order: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> $past(v1_reg))
        else $error("product valid without read");

    // The sum is taken only after the pipeline has drained.
    a_emit_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (!v1_reg && !v2_reg))
        else $error("result emitted with sums in flight");

    // A block completes only while idle, once every row of the previous one has gone to the output stage.
    a_block_start: assert property (@(posedge clk) disable iff (!rst_n)
        block_done |-> (fill_reg == ROW_W'(BLOCK_SIZE - 1)) && (state_reg == ST_IDLE))
        else $error("block completed outside idle");

endmodule
